// ----- rtl/core/u8a_pkg.sv -----
// ----------------------------------------------------------------------------
// u8a_pkg
// Shared types, constants and the code point mapping for the UTF-8 to
// ASCII sanitizer.
// ----------------------------------------------------------------------------
package u8a_pkg;

    // Decoder phase: which part of a multi-byte sequence is awaited
    typedef enum logic [1:0] {
        PHASE_IDLE        = 2'd0,
        PHASE_TWO_WAIT1   = 2'd1,
        PHASE_THREE_WAIT2 = 2'd2,
        PHASE_THREE_WAIT1 = 2'd3
    } phase_t;

    localparam int CHAR_W    = 7;
    localparam int PARTIAL_W = 10;

    // Mapped code points
    localparam logic [15:0] CP_LSQUO  = 16'h2018;
    localparam logic [15:0] CP_RSQUO  = 16'h2019;
    localparam logic [15:0] CP_LDQUO  = 16'h201C;
    localparam logic [15:0] CP_RDQUO  = 16'h201D;
    localparam logic [15:0] CP_ENDASH = 16'h2013;
    localparam logic [15:0] CP_EMDASH = 16'h2014;
    localparam logic [15:0] CP_ELLIP  = 16'h2026;

    // ASCII replacements and pass-through codes
    localparam logic [CHAR_W-1:0] CH_APOS   = 7'h27;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 7'h22;
    localparam logic [CHAR_W-1:0] CH_HYPHEN = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT    = 7'h2E;
    localparam logic [7:0]        BYTE_TAB  = 8'h09;
    localparam logic [7:0]        BYTE_LF   = 8'h0A;
    localparam logic [7:0]        BYTE_SP   = 8'h20;
    localparam logic [7:0]        BYTE_DEL  = 8'h7F;

    // Characters caused by one input byte: a repeat count of one character
    typedef struct packed {
        logic [1:0]        count;
        logic [CHAR_W-1:0] ch;
    } group_t;

    // Map a decoded three-byte code point to its ASCII group
    function automatic group_t map_code_point(input logic [15:0] cp);
        group_t g;
        g.count = 2'd0;
        g.ch    = CH_DOT;
        if (cp == CP_LSQUO || cp == CP_RSQUO) begin
            g.count = 2'd1;
            g.ch    = CH_APOS;
        end else if (cp == CP_LDQUO || cp == CP_RDQUO) begin
            g.count = 2'd1;
            g.ch    = CH_DQUOTE;
        end else if (cp == CP_ENDASH || cp == CP_EMDASH) begin
            g.count = 2'd1;
            g.ch    = CH_HYPHEN;
        end else if (cp == CP_ELLIP) begin
            g.count = 2'd3;
            g.ch    = CH_DOT;
        end
        return g;
    endfunction

endpackage

// ----- rtl/core/utf8_to_ascii_sanitizer.sv -----
// ----------------------------------------------------------------------------
// A result beat is registered: valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the result port is ready; a byte giving
// N characters holds the result register for N beats (three for the ellipsis).
// Reset: synchronous, active low; clears the pending sequence and result.
// ----------------------------------------------------------------------------
// utf8_to_ascii_sanitizer
// Decodes a UTF-8 byte stream and emits sanitized ASCII characters.
// ----------------------------------------------------------------------------
module utf8_to_ascii_sanitizer
    import u8a_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // piece_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] ascii_char, [7] zero
    output logic       m_tlast    // last_of_run
);

    logic              accept;
    logic              free;
    group_t            group;
    logic [CHAR_W-1:0] m_char;

    assign s_tready = free;
    assign accept   = s_tvalid && free;
    assign m_tdata  = {1'b0, m_char};

    u8a_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .data_byte (s_tdata),
        .piece_end (s_tlast),
        .group     (group)
    );

    u8a_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .group    (group),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_char   (m_char),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- rtl/core/u8a_decode.sv -----
// ----------------------------------------------------------------------------
// u8a_decode
// UTF-8 sequence tracker: holds the pending phase and gathered code bits,
// and turns each accepted byte into a group of ASCII characters.
// ----------------------------------------------------------------------------
module u8a_decode
    import u8a_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       piece_end,
    output group_t     group
);

    phase_t                 phase_reg, phase_next;
    logic [PARTIAL_W-1:0]   partial_reg, partial_next;

    logic        is_cont;
    logic [15:0] cp3;

    assign is_cont = (data_byte[7:6] == 2'b10);
    assign cp3     = {partial_reg, data_byte[5:0]};

    // Hold phase and partial code
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PHASE_IDLE;
            partial_reg <= '0;
        end else begin
            phase_reg   <= phase_next;
            partial_reg <= partial_next;
        end
    end

    // Advance the sequence and build the output group
    always_comb begin
        phase_next   = phase_reg;
        partial_next = partial_reg;
        group.count  = 2'd0;
        group.ch     = data_byte[CHAR_W-1:0];
        if (accept) begin
            if (phase_reg != PHASE_IDLE && is_cont) begin
                unique case (phase_reg)
                    PHASE_TWO_WAIT1: begin
                        // Two-byte code points never reach a mapped value
                        phase_next   = PHASE_IDLE;
                        partial_next = '0;
                    end
                    PHASE_THREE_WAIT2: begin
                        partial_next = {partial_reg[3:0], data_byte[5:0]};
                        phase_next   = PHASE_THREE_WAIT1;
                    end
                    PHASE_THREE_WAIT1: begin
                        group        = map_code_point(cp3);
                        phase_next   = PHASE_IDLE;
                        partial_next = '0;
                    end
                    default: begin
                        phase_next   = PHASE_IDLE;
                        partial_next = '0;
                    end
                endcase
            end else begin
                // Start fresh: pass printable ASCII, tab or newline, open a new sequence or drop
                phase_next   = PHASE_IDLE;
                partial_next = '0;
                if (data_byte == BYTE_LF || data_byte == BYTE_TAB ||
                    (data_byte >= BYTE_SP && data_byte < BYTE_DEL)) begin
                    group.count = 2'd1;
                end else if (data_byte[7:5] == 3'b110) begin
                    partial_next = {5'd0, data_byte[4:0]};
                    phase_next   = PHASE_TWO_WAIT1;
                end else if (data_byte[7:4] == 4'b1110) begin
                    partial_next = {6'd0, data_byte[3:0]};
                    phase_next   = PHASE_THREE_WAIT2;
                end
            end
            // Discard any pending sequence at piece end
            if (piece_end) begin
                phase_next   = PHASE_IDLE;
                partial_next = '0;
            end
        end
    end

endmodule

// ----- rtl/core/u8a_emit.sv -----
// ----------------------------------------------------------------------------
// u8a_emit
// Result register: holds one character group and sends it as zero to three
// beats, flagging the last one.
// ----------------------------------------------------------------------------
module u8a_emit
    import u8a_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  group_t            group,
    output logic              free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CHAR_W-1:0] m_char,
    output logic              m_tlast
);

    logic [1:0]        count_reg, count_next;
    logic [CHAR_W-1:0] char_reg, char_next;

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tlast  = (count_reg == 2'd1);
    assign m_char   = char_reg;
    // Free when empty or when the final beat leaves this cycle
    assign free     = (count_reg == 2'd0) || (count_reg == 2'd1 && m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        char_reg <= char_next;
    end

    // Load a new group or count down sent beats
    always_comb begin
        count_next = count_reg;
        char_next  = char_reg;
        if (load) begin
            count_next = group.count;
            char_next  = group.ch;
        end else if (m_tvalid && m_tready) begin
            count_next = count_reg - 2'd1;
        end
    end

endmodule

// ----- bench/tb_utf8_to_ascii_sanitizer.sv -----
// ----------------------------------------------------------------------------
// tb_utf8_to_ascii_sanitizer
// Self-checking bench for the UTF-8 to ASCII sanitizer. A short table of
// directed bytes is followed by random token streams (plain text, mapped
// punctuation, other code points, broken and cut-off sequences, noise).
// Each accepted byte runs through a local decoder model. The expected
// characters are queued, and every result beat is compared with the oldest
// entry. Both sides idle at random, with one stretch of no idling, one long
// hold-off on the result side and pauses until the output has drained.
// ----------------------------------------------------------------------------
module tb_utf8_to_ascii_sanitizer;
    import u8a_pkg::*;

    localparam int HOLD_CYCLES   = 48;
    localparam int RANDOM_BYTES  = 246;
    localparam int DIR_ROWS      = 24;
    localparam int MAX_REPORTS   = 10;

    // One expected character beat
    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_beat_t;

    // Directed table row; characters packed c0 in the lowest bits
    typedef struct packed {
        logic [7:0]  data;
        logic        piece_end;
        logic        typed;
        logic [1:0]  n;
        logic [20:0] chars;
    } dir_row_t;

    logic       aclk;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] data_byte
    logic       s_tlast  = 1'b0;    // piece_end
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [6:0] ascii_char, [7] zero
    logic       m_tlast;            // last_of_run

    // Typed expectation travelling with the byte on the input side
    logic        drv_typed = 1'b0;
    logic [1:0]  drv_n     = 2'd0;
    logic [20:0] drv_chars = '0;

    // Decoder model state
    phase_t                 dec_phase   = PHASE_IDLE;
    logic [PARTIAL_W-1:0]   dec_partial = '0;

    char_beat_t pending_chars [$];

    int  mismatches    = 0;
    int  bytes_sent    = 0;
    int  bytes_taken   = 0;
    int  chars_checked = 0;
    int  ellipses      = 0;
    int  tx_idle_pct   = 35;
    int  rx_idle_pct   = 35;
    bit  hold_req      = 1'b0;

    logic [7:0] punct_tail [11] = '{8'h98, 8'h99, 8'h9C, 8'h9D, 8'h93, 8'h94, 8'hA6,
                                    8'h97, 8'hA7, 8'h92, 8'h9E};

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{8'h41, 1'b0, 1'b1, 2'd1, {14'd0, 7'h41}},            // plain letter
        '{8'h09, 1'b0, 1'b1, 2'd1, {14'd0, 7'h09}},            // tab
        '{8'h0A, 1'b0, 1'b1, 2'd1, {14'd0, 7'h0A}},            // newline
        '{8'h20, 1'b0, 1'b1, 2'd1, {14'd0, 7'h20}},            // lowest printable
        '{8'h7E, 1'b1, 1'b1, 2'd1, {14'd0, 7'h7E}},            // highest printable, piece end
        '{8'h7F, 1'b0, 1'b1, 2'd0, 21'd0},                     // DEL dropped
        '{8'h01, 1'b0, 1'b1, 2'd0, 21'd0},                     // control dropped
        '{8'hFF, 1'b0, 1'b1, 2'd0, 21'd0},                     // invalid byte dropped
        '{8'h80, 1'b0, 1'b1, 2'd0, 21'd0},                     // stray continuation
        '{8'hE2, 1'b0, 1'b0, 2'd0, 21'd0},                     // ellipsis
        '{8'h80, 1'b0, 1'b0, 2'd0, 21'd0},
        '{8'hA6, 1'b0, 1'b1, 2'd3, {CH_DOT, CH_DOT, CH_DOT}},
        '{8'hE2, 1'b0, 1'b0, 2'd0, 21'd0},                     // left single quote
        '{8'h80, 1'b0, 1'b0, 2'd0, 21'd0},
        '{8'h98, 1'b0, 1'b0, 2'd0, 21'd0},
        '{8'hE2, 1'b0, 1'b0, 2'd0, 21'd0},                     // broken by a letter
        '{8'h5A, 1'b0, 1'b0, 2'd0, 21'd0},
        '{8'hE2, 1'b0, 1'b0, 2'd0, 21'd0},                     // cut off at piece end
        '{8'h80, 1'b1, 1'b0, 2'd0, 21'd0},
        '{8'hA6, 1'b0, 1'b0, 2'd0, 21'd0},
        '{8'hF0, 1'b0, 1'b0, 2'd0, 21'd0},                     // four-byte lead
        '{8'h9F, 1'b0, 1'b0, 2'd0, 21'd0},
        '{8'hC3, 1'b0, 1'b0, 2'd0, 21'd0},                     // two-byte, unmapped
        '{8'hA9, 1'b1, 1'b0, 2'd0, 21'd0}
    };

    utf8_to_ascii_sanitizer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Decode one byte into zero to three characters and advance the model
    function automatic int decode_byte(input logic [7:0] b, input logic pe,
                                       output logic [20:0] chars);
        logic [15:0] cp;
        bit          done;
        int          n;
        cp    = '0;
        done  = 1'b0;
        n     = 0;
        chars = '0;
        if (dec_phase != PHASE_IDLE && b[7:6] == 2'b10) begin
            case (dec_phase)
                PHASE_TWO_WAIT1: begin
                    cp   = {5'd0, dec_partial[4:0], b[5:0]};
                    done = 1'b1;
                end
                PHASE_THREE_WAIT2: begin
                    dec_partial = {dec_partial[3:0], b[5:0]};
                    dec_phase   = PHASE_THREE_WAIT1;
                end
                default: begin
                    cp   = {dec_partial, b[5:0]};
                    done = 1'b1;
                end
            endcase
            if (done) begin
                dec_phase   = PHASE_IDLE;
                dec_partial = '0;
            end
        end else begin
            // Start fresh: any pending sequence is lost
            dec_phase   = PHASE_IDLE;
            dec_partial = '0;
            if (b == BYTE_LF || b == BYTE_TAB || (b >= BYTE_SP && b < BYTE_DEL)) begin
                chars[6:0] = b[6:0];
                n = 1;
            end else if (b[7:5] == 3'b110) begin
                dec_partial = {5'd0, b[4:0]};
                dec_phase   = PHASE_TWO_WAIT1;
            end else if (b[7:4] == 4'b1110) begin
                dec_partial = {6'd0, b[3:0]};
                dec_phase   = PHASE_THREE_WAIT2;
            end
        end
        if (done) begin
            case (cp)
                CP_LSQUO, CP_RSQUO: begin
                    chars[6:0] = CH_APOS;
                    n = 1;
                end
                CP_LDQUO, CP_RDQUO: begin
                    chars[6:0] = CH_DQUOTE;
                    n = 1;
                end
                CP_ENDASH, CP_EMDASH: begin
                    chars[6:0] = CH_HYPHEN;
                    n = 1;
                end
                CP_ELLIP: begin
                    chars = {CH_DOT, CH_DOT, CH_DOT};
                    n = 3;
                end
                default: ;
            endcase
        end
        // Discard whatever is still pending at the end of a piece
        if (pe) begin
            dec_phase   = PHASE_IDLE;
            dec_partial = '0;
        end
        return n;
    endfunction

    // Queue expectations for accepted bytes, then check result beats
    always @(posedge aclk) begin : p_scoreboard
        logic [20:0] chars;
        int          n;
        char_beat_t  beat;
        char_beat_t  want;
        if (aresetn && s_tvalid && s_tready) begin
            n = decode_byte(s_tdata, s_tlast, chars);
            if (drv_typed) begin
                n     = int'(drv_n);
                chars = drv_chars;
            end
            if (n == 3)
                ellipses++;
            bytes_taken++;
            for (int i = 0; i < n; i++) begin
                beat.ch   = chars[7*i +: 7];
                beat.last = (i == n - 1);
                pending_chars.push_back(beat);
            end
        end
        if (aresetn && m_tvalid && m_tready) begin
            chars_checked++;
            if (pending_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] unexpected beat: tdata=%h tlast=%b",
                             $realtime, m_tdata, m_tlast);
            end else begin
                want = pending_chars.pop_front();
                if (m_tdata !== {1'b0, want.ch} || m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("[%0t] mismatch: tdata exp %h got %h, tlast exp %b got %b",
                                 $realtime, {1'b0, want.ch}, m_tdata, want.last, m_tlast);
                end
            end
        end
    end

    // Result-side ready: random idling, or a long counted hold-off on request
    initial begin : p_receiver
        int held;
        held = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                held++;
                if (held == HOLD_CYCLES) begin
                    hold_req = 1'b0;
                    held     = 0;
                end
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Offer one byte, idling at random first, and hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic pe, input logic typed,
                             input logic [1:0] n, input logic [20:0] chars);
        @(negedge aclk);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= b;
        s_tlast   <= pe;
        drv_typed <= typed;
        drv_n     <= n;
        drv_chars <= chars;
        do
            @(posedge aclk);
        while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_random(input logic [7:0] b);
        send_byte(b, ($urandom_range(99) < 8), 1'b0, 2'd0, 21'd0);
    endtask

    // Send one random token: mostly well-formed text, some noise
    task automatic send_token();
        int         kind;
        int         cnt;
        logic [7:0] lead;
        kind = $urandom_range(99);
        if (kind < 30) begin
            cnt = $urandom_range(1, 4);
            repeat (cnt) begin
                if ($urandom_range(9) == 0)
                    send_random($urandom_range(1) ? BYTE_TAB : BYTE_LF);
                else
                    send_random(8'($urandom_range(8'h20, 8'h7E)));
            end
        end else if (kind < 55) begin
            // Mapped punctuation, with a few near misses
            send_random(8'hE2);
            send_random(8'h80);
            if ($urandom_range(3) == 0)
                send_random(punct_tail[$urandom_range(7, 10)]);
            else
                send_random(punct_tail[$urandom_range(0, 6)]);
        end else if (kind < 65) begin
            send_random(8'($urandom_range(8'hE0, 8'hEF)));
            send_random(8'($urandom_range(8'h80, 8'hBF)));
            send_random(8'($urandom_range(8'h80, 8'hBF)));
        end else if (kind < 75) begin
            send_random(8'($urandom_range(8'hC0, 8'hDF)));
            send_random(8'($urandom_range(8'h80, 8'hBF)));
        end else if (kind < 83) begin
            // Broken sequence: lead, maybe one continuation, then a non-continuation
            lead = 8'($urandom_range(8'hC0, 8'hEF));
            send_random(lead);
            if (lead[7:4] == 4'b1110 && $urandom_range(1))
                send_random(8'($urandom_range(8'h80, 8'hBF)));
            if ($urandom_range(1))
                send_random(8'($urandom_range(8'h01, 8'h7F)));
            else
                send_random(8'($urandom_range(8'hC0, 8'hFF)));
        end else if (kind < 89) begin
            send_random(8'($urandom_range(8'h80, 8'hBF)));
        end else if (kind < 94) begin
            send_random(8'($urandom_range(8'hF0, 8'hFF)));
        end else begin
            if ($urandom_range(4) == 0)
                send_random(BYTE_DEL);
            else
                send_random(8'($urandom_range(8'h01, 8'h1F)));
        end
    endtask

    // Drop valid and wait for every expected character to drain
    task automatic drain_output();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge aclk);
    endtask

    initial begin : p_main
        int target;
        int waited;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table
        for (int r = 0; r < DIR_ROWS; r++)
            send_byte(dir_rows[r].data, dir_rows[r].piece_end, dir_rows[r].typed,
                      dir_rows[r].n, dir_rows[r].chars);

        // Back-to-back stretch with no idling on either side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        target = bytes_sent + 60;
        while (bytes_sent < target)
            send_token();
        drain_output();

        // Long hold-off on the result side while bytes keep coming
        hold_req = 1'b1;
        target = bytes_sent + 30;
        while (bytes_sent < target)
            send_token();
        rx_idle_pct = 35;
        drain_output();

        // Random idling on both sides for the rest
        tx_idle_pct = 35;
        target = DIR_ROWS + RANDOM_BYTES;
        while (bytes_sent < target) begin
            send_token();
            if ($urandom_range(59) == 0)
                drain_output();
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_chars.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (10) @(posedge aclk);
        if (pending_chars.size() != 0) begin
            $display("%0d expected characters never arrived", pending_chars.size());
            mismatches += pending_chars.size();
        end

        $display("Covered %0d bytes (%0d directed), %0d characters checked, %0d ellipses.",
                 bytes_taken, DIR_ROWS, chars_checked, ellipses);
        $display("Included back-to-back traffic, a %0d-cycle output hold-off and drains.",
                 HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("** utf8_to_ascii_sanitizer: PASSED **");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("** utf8_to_ascii_sanitizer: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #400000;
        $display("timeout with %0d characters outstanding", pending_chars.size());
        $display("** utf8_to_ascii_sanitizer: FAILED **");
        $finish;
    end

endmodule
